// File: rtl/assert_macros.svh
// assertion macros used by lslf_dp
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("assertion failed");
// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk_s, rst_s, cond) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
    else $error("forbidden condition seen");
`endif

// File: rtl/lslf_pkg.sv
// package for the least-squares line fit unit
// shared constants, types and the controller command/status structs
package lslf_pkg;

  localparam int unsigned MAX_POINTS_DEF    = 1024;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // fit status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DEN = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_OVF = 2'd3;

  // product step select
  localparam logic [1:0] PS_NONE = 2'd0;
  localparam logic [1:0] PS_NUM1 = 2'd1;  // n*sxy and sx*sy
  localparam logic [1:0] PS_NUM0 = 2'd2;  // sy*sxx and sx*sxy
  localparam logic [1:0] PS_DEN  = 2'd3;  // n*sxx and sx*sx

  typedef enum logic [3:0] {
    S_ACC,    // accumulate points
    S_P1,     // products group 1
    S_P2,     // products group 2
    S_P3,     // products group 3 and den
    S_CHK,    // classify
    S_DSET1,  // set up slope division
    S_DIV1,
    S_DSET2,  // set up intercept division
    S_DIV2,
    S_OUT     // result waits for transfer
  } state_t;

  typedef struct packed {
    logic acc;      // accumulate accepted point
    logic clr;      // clear sums
    logic [1:0] prod; // product step select
    logic prod_en;
    logic dset;     // load divider
    logic dsel;     // 0 slope, 1 intercept
    logic dstep;    // one divider step
    logic dfin;     // store quotient
    logic chk;      // latch status
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic ovf;
    logic div_done;
    logic mul_done;
  } sts_t;

endpackage

// File: rtl/lslf_ctrl.sv
// controller state machine of the line fit unit
// depends on lslf_pkg
module lslf_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_last_point,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output lslf_pkg::cmd_t cmd,
  input  lslf_pkg::sts_t sts
);

  lslf_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lslf_pkg::S_ACC;
    else state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lslf_pkg::S_ACC: begin
        if (in_valid && in_last_point) state_nxt = lslf_pkg::S_P1;
      end
      lslf_pkg::S_P1: begin
        if (sts.mul_done) state_nxt = lslf_pkg::S_P2;
      end
      lslf_pkg::S_P2: begin
        if (sts.mul_done) state_nxt = lslf_pkg::S_P3;
      end
      lslf_pkg::S_P3: begin
        if (sts.mul_done) state_nxt = lslf_pkg::S_CHK;
      end
      lslf_pkg::S_CHK: begin
        if (sts.ovf || sts.den_zero) state_nxt = lslf_pkg::S_OUT;
        else state_nxt = lslf_pkg::S_DSET1;
      end
      lslf_pkg::S_DSET1: state_nxt = lslf_pkg::S_DIV1;
      lslf_pkg::S_DIV1: begin
        if (sts.div_done) state_nxt = lslf_pkg::S_DSET2;
      end
      lslf_pkg::S_DSET2: state_nxt = lslf_pkg::S_DIV2;
      lslf_pkg::S_DIV2: begin
        if (sts.div_done) state_nxt = lslf_pkg::S_OUT;
      end
      lslf_pkg::S_OUT: begin
        if (out_ready) state_nxt = lslf_pkg::S_ACC;
      end
      default: state_nxt = lslf_pkg::S_ACC;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      lslf_pkg::S_ACC: begin
        in_ready = 1'b1;
        cmd.acc = in_valid;
      end
      lslf_pkg::S_P1: begin
        cmd.prod = lslf_pkg::PS_NUM1;
        cmd.prod_en = 1'b1;
      end
      lslf_pkg::S_P2: begin
        cmd.prod = lslf_pkg::PS_NUM0;
        cmd.prod_en = 1'b1;
      end
      lslf_pkg::S_P3: begin
        cmd.prod = lslf_pkg::PS_DEN;
        cmd.prod_en = 1'b1;
      end
      lslf_pkg::S_CHK: cmd.chk = 1'b1;
      lslf_pkg::S_DSET1: cmd.dset = 1'b1;
      lslf_pkg::S_DIV1: begin
        cmd.dstep = 1'b1;
        cmd.dfin = sts.div_done;
      end
      lslf_pkg::S_DSET2: begin
        cmd.dset = 1'b1;
        cmd.dsel = 1'b1;
      end
      lslf_pkg::S_DIV2: begin
        cmd.dstep = 1'b1;
        cmd.dsel = 1'b1;
        cmd.dfin = sts.div_done;
      end
      lslf_pkg::S_OUT: begin
        out_valid = 1'b1;
        cmd.clr = out_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/lslf_dp.sv
// datapath of the line fit unit: sums, product steps and serial divider
// depends on lslf_pkg and assert_macros.svh
`include "assert_macros.svh"
module lslf_dp #(
  parameter int unsigned MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRACTION_BITS = lslf_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  lslf_pkg::cmd_t cmd,
  output lslf_pkg::sts_t sts,
  output logic signed [31:0] slope,
  output logic signed [31:0] intercept,
  output logic [1:0] fit_status
);

  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int SXW = 17 + CW;        // sum of x / y
  localparam int SQW = 31 + CW;        // sum of x squared (unsigned)
  localparam int SPW = 32 + CW;        // sum of x*y
  localparam int MW  = 128;            // wide numerator space
  localparam int NW  = MW + FRACTION_BITS + 2; // dividend width
  localparam int QW  = NW;
  localparam int DW  = 64;
  localparam int SW  = $clog2(NW + 1);
  localparam int ND  = (SPW + 15) / 16; // 16-bit digits per product operand
  localparam int OW  = 16 * ND;         // product operand width

  logic [CW-1:0]          cnt_r;
  logic signed [SXW-1:0]  sx_r, sy_r;
  logic [SQW-1:0]         sxx_r;
  logic signed [SPW-1:0]  sxy_r;
  logic                   ovf_r;

  // accumulation, one point per transfer
  logic signed [31:0] px_sq, pxy;
  assign px_sq = in_sample_x * in_sample_x;
  assign pxy   = in_sample_x * in_sample_y;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      cnt_r <= '0; sx_r <= '0; sy_r <= '0; sxx_r <= '0; sxy_r <= '0; ovf_r <= 1'b0;
    end else if (cmd.acc) begin
      if (cnt_r >= CW'(MAX_POINTS)) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        sx_r  <= sx_r + SXW'(in_sample_x);
        sy_r  <= sy_r + SXW'(in_sample_y);
        sxx_r <= sxx_r + SQW'($unsigned(px_sq));
        sxy_r <= sxy_r + SPW'(pxy);
      end
    end
  end

  // product steps: step 1 n*sxy and sx*sy, step 2 sy*sxx and sx*sxy,
  // step 3 n*sxx and sx*sx; each product is summed one 16-bit digit of
  // its second operand at a time, registered when its last digit is in
  logic signed [MW-1:0] pa_r, pb_r, a1_r, a0_r;
  logic signed [MW-1:0] pacc_r, pbacc_r;
  logic signed [MW-1:0] den_s;
  logic signed [OW-1:0] op_a1, op_b1, op_a2, op_b2;
  logic [1:0]           dig_r;
  logic [15:0]          dg1, dg2;
  logic                 top_dig;
  logic signed [16:0]   sd1, sd2;
  logic signed [OW+16:0] pp1, pp2;
  logic signed [MW-1:0] sh1, sh2, sum1, sum2;

  always_comb begin
    op_a1 = OW'($signed({1'b0, cnt_r}));
    op_b1 = OW'(sxy_r);
    op_a2 = OW'(sx_r);
    op_b2 = OW'(sy_r);
    case (cmd.prod)
      lslf_pkg::PS_NUM0: begin
        op_a1 = OW'(sy_r);
        op_b1 = OW'($signed({1'b0, sxx_r}));
        op_a2 = OW'(sx_r);
        op_b2 = OW'(sxy_r);
      end
      lslf_pkg::PS_DEN: begin
        op_a1 = OW'($signed({1'b0, cnt_r}));
        op_b1 = OW'($signed({1'b0, sxx_r}));
        op_a2 = OW'(sx_r);
        op_b2 = OW'(sx_r);
      end
      default: ;
    endcase
  end

  // one digit partial product per cycle, top digit taken as signed
  always_comb begin
    dg1 = op_b1[{dig_r, 4'b0000} +: 16];
    dg2 = op_b2[{dig_r, 4'b0000} +: 16];
    top_dig = (dig_r == 2'(ND - 1));
    sd1 = $signed({top_dig & dg1[15], dg1});
    sd2 = $signed({top_dig & dg2[15], dg2});
    pp1 = op_a1 * sd1;
    pp2 = op_a2 * sd2;
    sh1 = MW'(pp1) << {dig_r, 4'b0000};
    sh2 = MW'(pp2) << {dig_r, 4'b0000};
    sum1 = (dig_r == 2'd0) ? sh1 : pacc_r + sh1;
    sum2 = (dig_r == 2'd0) ? sh2 : pbacc_r + sh2;
  end
  assign sts.mul_done = top_dig;

  // digit counter
  always_ff @(posedge clk) begin
    if (!rst_n) dig_r <= '0;
    else if (cmd.prod_en) dig_r <= top_dig ? 2'd0 : dig_r + 2'd1;
  end

  // partial sums; pa_r/pb_r hold the previous step's products until the
  // current step finishes, so the difference lands a step later
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      pacc_r  <= sum1;
      pbacc_r <= sum2;
      if (top_dig) begin
        pa_r <= sum1;
        pb_r <= sum2;
      end
    end
    if (cmd.prod == lslf_pkg::PS_NUM0) a1_r <= pa_r - pb_r;
    if (cmd.prod == lslf_pkg::PS_DEN) a0_r <= pa_r - pb_r;
  end

  // den is valid in check state (products of step 3 in pa_r/pb_r)
  logic [DW-1:0] den_r;
  assign den_s = pa_r - pb_r;
  logic [1:0] stat_r;
  logic sat_r;
  always_ff @(posedge clk) begin
    if (cmd.chk) den_r <= den_s[DW-1:0];
  end
  assign sts.den_zero = (den_s[DW-1:0] == '0);
  assign sts.ovf = ovf_r;

  // restoring divider, one quotient bit per cycle
  logic [NW-1:0] dvd_r;
  logic [DW:0]   rem_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] step_r;
  logic          neg_r;
  logic signed [MW-1:0] num_sel;
  logic [MW-1:0] num_mag;
  logic [DW+1:0] rsh, rdif;

  assign num_sel = cmd.dsel ? a0_r : a1_r;
  assign num_mag = num_sel[MW-1] ? MW'(-num_sel) : MW'(num_sel);
  assign rsh  = {rem_r, dvd_r[NW-1]};
  assign rdif = rsh - {1'b0, den_r, 1'b0};
  assign sts.div_done = (step_r == SW'(NW - 1));

  always_ff @(posedge clk) begin
    if (cmd.dset) begin
      dvd_r  <= (NW'(num_mag) << (FRACTION_BITS + 1)) + NW'(den_r);
      rem_r  <= '0;
      quo_r  <= '0;
      step_r <= '0;
      neg_r  <= num_sel[MW-1];
    end else if (cmd.dstep) begin
      dvd_r  <= dvd_r << 1;
      step_r <= step_r + 1'b1;
      if (!rdif[DW+1]) begin
        rem_r <= rdif[DW:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rsh[DW:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  // final quotient incl. this step's bit, with saturation
  logic [QW-1:0] qfin;
  logic [31:0]   qres;
  logic          qsat;
  assign qfin = {quo_r[QW-2:0], ~rdif[DW+1]};
  always_comb begin
    if (neg_r) begin
      qsat = (qfin > QW'(32'h8000_0000));
      qres = qsat ? 32'h8000_0000 : (32'd0 - qfin[31:0]);
    end else begin
      qsat = (qfin > QW'(32'h7FFF_FFFF));
      qres = qsat ? 32'h7FFF_FFFF : qfin[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      slope <= '0;
      intercept <= '0;
      sat_r <= 1'b0;
      stat_r <= ovf_r ? lslf_pkg::ST_OVF :
                (den_s[DW-1:0] == '0) ? lslf_pkg::ST_DEN : lslf_pkg::ST_OK;
    end else if (cmd.dfin) begin
      if (cmd.dsel) intercept <= qres;
      else slope <= qres;
      if (qsat) begin
        sat_r <= 1'b1;
        stat_r <= lslf_pkg::ST_SAT;
      end
    end
  end
  assign fit_status = stat_r;

  // divider finish only while stepping
  `ASSERT_CLK(a_fin_step, clk, rst_n, cmd.dfin |-> cmd.dstep)
  // saturation flag and status agree in the cycle after a saturating quotient store
  `ASSERT_CLK(a_sat_stat, clk, rst_n, (cmd.dfin && qsat) |=> (stat_r == lslf_pkg::ST_SAT && sat_r))
  // count never exceeds the run limit
  `ASSERT_CLK(a_cnt_max, clk, rst_n, cnt_r <= CW'(MAX_POINTS))
  // digit counter stays within one product
  `ASSERT_CLK(a_dig_range, clk, rst_n, dig_r <= 2'(ND - 1))
  // divider is never loaded and stepped together
  `ASSERT_NEVER(a_set_step, clk, rst_n, cmd.dset && cmd.dstep)

endmodule

// File: rtl/least_squares_line_fit_unit.sv
// top level of the least-squares line fit unit
// depends on lslf_pkg, lslf_ctrl, lslf_dp
//
// usage: points (in_sample_x, in_sample_y, in_last_point) arrive on a
// valid/ready input channel and are summed at one transfer per cycle
// while in_ready is high. a point with in_last_point set ends the run:
// the unit stops taking input, forms the sum products (three 16-bit
// digit steps per product pair), checks the denominator, then runs a
// restoring divider one quotient bit per cycle, once for the slope and
// once for the intercept, each after a setup state. out_valid is set
// once the serial divider finishes; a run with zero denominator or too
// many points skips the divider. the result holds on out_* until the
// receiver takes it; while out_ready stays low the unit waits and takes
// no input. after the result transfer the sums clear and a new run begins.
// reset (rst_n low, synchronous) clears all sums and returns to accepting.
module least_squares_line_fit_unit #(
  parameter int unsigned MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
  parameter int unsigned FRACTION_BITS = lslf_pkg::FRACTION_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic in_last_point,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] out_slope,
  output logic signed [31:0] out_intercept,
  output logic [1:0] out_fit_status
);

  lslf_pkg::cmd_t cmd;
  lslf_pkg::sts_t sts;

  lslf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_last_point, .in_ready,
    .out_valid, .out_ready, .cmd, .sts
  );

  lslf_dp #(.MAX_POINTS(MAX_POINTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk, .rst_n, .in_sample_x, .in_sample_y, .cmd, .sts,
    .slope(out_slope), .intercept(out_intercept), .fit_status(out_fit_status)
  );

endmodule

// File: tb/least_squares_line_fit_unit_tb.sv
// testbench for the least-squares line fit unit: random and directed point runs
// depends on lslf_pkg and least_squares_line_fit_unit; checks fits with a local predictor
module least_squares_line_fit_unit_tb;

  localparam int unsigned RUN_CAP  = lslf_pkg::MAX_POINTS_DEF;
  localparam int unsigned FRAC     = lslf_pkg::FRACTION_BITS_DEF;

  typedef struct {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [1:0]         status;
  } fit_t;

  // line fit predictor and queue of expected fits
  class fit_scoreboard;
    int unsigned        npts;
    longint             sx, sxx, sy, sxy;
    bit                 too_long;
    fit_t               fits_due[$];
    int unsigned        mismatches, fits_seen, points_seen;

    function void clear_sums();
      npts = 0; sx = 0; sxx = 0; sy = 0; sxy = 0; too_long = 0;
    endfunction

    // rounded quotient num * 2^FRAC / den, clamped to 32 bits
    function logic [31:0] quot(logic signed [127:0] num, logic [127:0] den, ref bit sat);
      logic [127:0] m, q;
      bit neg;
      neg = num < 0;
      m = neg ? -num : num;
      m = (m << (FRAC + 1)) + den;
      q = m / (den << 1);
      if (neg) begin
        if (q > 128'h8000_0000) begin sat = 1; return 32'h8000_0000; end
        return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) begin sat = 1; return 32'h7FFF_FFFF; end
      return q[31:0];
    endfunction

    // note one accepted point transfer
    function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
      longint xl, yl;
      logic signed [127:0] n_w, sx_w, sxx_w, sy_w, sxy_w, a1, a0, den;
      fit_t f;
      bit sat;
      xl = x; yl = y;
      points_seen++;
      if (npts >= RUN_CAP) too_long = 1;
      else begin
        npts++; sx += xl; sxx += xl * xl; sy += yl; sxy += xl * yl;
      end
      if (!last) return;
      n_w = npts; sx_w = sx; sxx_w = sxx; sy_w = sy; sxy_w = sxy;
      den = n_w * sxx_w - sx_w * sx_w;
      f.slope = 0; f.intercept = 0;
      if (too_long) f.status = lslf_pkg::ST_OVF;
      else if (den == 0) f.status = lslf_pkg::ST_DEN;
      else begin
        sat = 0;
        a1 = n_w * sxy_w - sx_w * sy_w;
        a0 = sy_w * sxx_w - sx_w * sxy_w;
        f.slope = quot(a1, den, sat);
        f.intercept = quot(a0, den, sat);
        f.status = sat ? lslf_pkg::ST_SAT : lslf_pkg::ST_OK;
      end
      fits_due.push_back(f);
      clear_sums();
    endfunction

    // compare one result transfer with the oldest expected fit
    function void check_fit(logic signed [31:0] s, logic signed [31:0] c, logic [1:0] st);
      fit_t f;
      fits_seen++;
      if (fits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: slope %0d intercept %0d status %0d",
                                       s, c, st);
        return;
      end
      f = fits_due.pop_front();
      if (s !== f.slope || c !== f.intercept || st !== f.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("fit %0d mismatch: exp slope %0d icpt %0d st %0d, got %0d %0d %0d",
                   fits_seen, f.slope, f.intercept, f.status, s, c, st);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_point;
  logic signed [15:0] in_sample_x, in_sample_y;
  logic out_valid, out_ready;
  logic signed [31:0] out_slope, out_intercept;
  logic [1:0] out_fit_status;

  fit_scoreboard sb;
  bit calm;          // no random idling on either side
  int hold_request;  // cycles the receiver should hold off
  int runs_done;

  least_squares_line_fit_unit u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // generous run limit
  initial begin
    #30_000_000;
    $display("timeout");
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls and one long hold-off
  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_fit(out_slope, out_intercept, out_fit_status);
      @(negedge clk);
      if (hold_request > 0) begin hold = hold_request; hold_request = 0; end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // drive one point and wait for its transfer
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1; in_sample_x <= x; in_sample_y <= y; in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_point(x, y, last);
    if (last) runs_done++;
    @(negedge clk);
  endtask

  // stop offering and wait until every expected fit has come
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.fits_due.size() != 0);
  endtask

  // one run of random shape
  task automatic send_run(int len);
    int kind, slope_i, base, cx;
    kind = $urandom_range(9);
    slope_i = $signed($urandom_range(0, 200)) - 100;
    base = $signed($urandom_range(0, 2000)) - 1000;
    cx = $signed($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      logic signed [15:0] x, y;
      case (kind)
        0, 1, 2: begin x = 16'($urandom); y = 16'($urandom); end
        3: begin x = 16'(cx); y = 16'($urandom); end
        4: begin x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000; y = 16'($urandom); end
        default: begin
          x = 16'(i * 3 + base);
          y = 16'(slope_i * (i * 3) + base + $signed($urandom_range(0, 20)) - 10);
        end
      endcase
      send_point(x, y, i == len - 1);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_sums();
    calm = 0; hold_request = 0; runs_done = 0;
    rst_n = 0; in_valid = 0; in_sample_x = 0; in_sample_y = 0; in_last_point = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: single point, equal x, extremes, saturation, exact line
    send_point(16'sh7FFF, 16'sh8000, 1'b1);
    send_point(16'sd5, 16'sd1, 1'b0); send_point(16'sd5, 16'sd9, 1'b0);
    send_point(16'sd5, -16'sd3, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0); send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_point(16'sd0, 16'sh8000, 1'b0); send_point(16'sd1, 16'sh7FFF, 1'b1);
    send_point(16'sd0, 16'sh7FFF, 1'b0); send_point(16'sd1, 16'sh8000, 1'b1);
    send_point(16'sh8000, 16'sh7FFF, 1'b0); send_point(16'sh7FFF, 16'sh8000, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(-16'sd2, -16'sd3, 1'b0); send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd2, 16'sd5, 1'b0); send_point(16'sd4, 16'sd9, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0); send_point(16'sd3, 16'sd1, 1'b1);

    // receiver holds off while the sender keeps offering
    hold_request = 700;
    send_run(3); send_run(4); send_run(2);
    drain();

    // run beyond the point limit, with no idling on either side
    calm = 1;
    send_run(RUN_CAP + 1);
    calm = 0;

    // random runs
    while (sb.points_seen < 1200) begin
      if ($urandom_range(19) == 0) drain();
      send_run(int'($urandom_range(1, 14)));
    end
    drain();
    repeat (400) @(negedge clk);

    $display("covered %0d points in %0d runs, %0d fits checked",
             sb.points_seen, runs_done, sb.fits_seen);
    if (sb.mismatches == 0 && sb.fits_due.size() == 0)
      $display("PASSED: all results match");
    else begin
      $display("%0d mismatches, %0d fits missing", sb.mismatches, sb.fits_due.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+rtl
rtl/lslf_pkg.sv
rtl/lslf_ctrl.sv
rtl/lslf_dp.sv
rtl/least_squares_line_fit_unit.sv
tb/least_squares_line_fit_unit_tb.sv
